// ===== rtl/core/sdcsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdcsd_pkg
// Types, codes and lookup tables shared by the CSD register decoder.
// ----------------------------------------------------------------------------
package sdcsd_pkg;

    // structure version codes (bits 127:126)
    localparam logic [1:0] VER_STD = 2'd0;
    localparam logic [1:0] VER_HC  = 2'd1;

    // decode status codes
    localparam logic [1:0] STATUS_STD = 2'd0;
    localparam logic [1:0] STATUS_HC  = 2'd1;
    localparam logic [1:0] STATUS_BAD = 2'd2;

    // fixed high-capacity values
    localparam logic [3:0] HC_BLOCK_BITS = 4'd9;
    localparam logic [2:0] HC_WR_SPEED   = 3'd4;
    localparam logic [6:0] NSAC_SCALE    = 7'd100;

    typedef struct packed {
        logic [63:0] csd_high;
        logic [63:0] csd_low;
    } t_csd_in;

    typedef struct packed {
        logic [1:0]  decode_status;
        logic [26:0] access_time_ns;
        logic [14:0] access_time_clocks;
        logic [29:0] max_transfer_rate;
        logic [11:0] command_classes;
        logic [32:0] capacity_blocks;
        logic [3:0]  read_block_bits;
        logic [3:0]  write_block_bits;
        logic [2:0]  write_speed_factor;
        logic [3:0]  access_flags;
    } t_csd_out;

    // fields pulled out of the register, with table values already looked up
    typedef struct packed {
        logic [1:0]  ver;
        logic [23:0] rate_unit;
        logic [6:0]  rate_mant;
        logic [11:0] ccc;
        logic        time_unit_ns;
        logic [19:0] time_unit;
        logic [6:0]  time_mant;
        logic [3:0]  time_small;
        logic [7:0]  nsac;
        logic [11:0] csize_std;
        logic [2:0]  size_mult;
        logic [21:0] csize_hc;
        logic [3:0]  read_bl_len;
        logic [3:0]  write_bl_len;
        logic [2:0]  wr_speed_code;
        logic [3:0]  flags;
    } t_csd_fields;

    // mantissa times ten
    function automatic logic [6:0] mant_value(input logic [3:0] code);
        logic [6:0] v;
        case (code)
            4'd1:    v = 7'd10;
            4'd2:    v = 7'd12;
            4'd3:    v = 7'd13;
            4'd4:    v = 7'd15;
            4'd5:    v = 7'd20;
            4'd6:    v = 7'd25;
            4'd7:    v = 7'd30;
            4'd8:    v = 7'd35;
            4'd9:    v = 7'd40;
            4'd10:   v = 7'd45;
            4'd11:   v = 7'd50;
            4'd12:   v = 7'd55;
            4'd13:   v = 7'd60;
            4'd14:   v = 7'd70;
            4'd15:   v = 7'd80;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    // mantissa divided by ten, rounded up (1 ns exponent)
    function automatic logic [3:0] mant_ceil_tenth(input logic [3:0] code);
        logic [3:0] v;
        case (code)
            4'd1:    v = 4'd1;
            4'd2:    v = 4'd2;
            4'd3:    v = 4'd2;
            4'd4:    v = 4'd2;
            4'd5:    v = 4'd2;
            4'd6:    v = 4'd3;
            4'd7:    v = 4'd3;
            4'd8:    v = 4'd4;
            4'd9:    v = 4'd4;
            4'd10:   v = 4'd5;
            4'd11:   v = 4'd5;
            4'd12:   v = 4'd6;
            4'd13:   v = 4'd6;
            4'd14:   v = 4'd7;
            4'd15:   v = 4'd8;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    // access time unit divided by ten (exact for exponent codes 1 to 7)
    function automatic logic [19:0] time_unit_tenth(input logic [2:0] code);
        logic [19:0] v;
        case (code)
            3'd1:    v = 20'd1;
            3'd2:    v = 20'd10;
            3'd3:    v = 20'd100;
            3'd4:    v = 20'd1000;
            3'd5:    v = 20'd10000;
            3'd6:    v = 20'd100000;
            3'd7:    v = 20'd1000000;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // transfer rate unit divided by ten; reserved codes give zero
    function automatic logic [23:0] rate_unit_tenth(input logic [2:0] code);
        logic [23:0] v;
        case (code)
            3'd0:    v = 24'd10000;
            3'd1:    v = 24'd100000;
            3'd2:    v = 24'd1000000;
            3'd3:    v = 24'd10000000;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sdcsd_unpack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdcsd_unpack
// Slices the 128-bit CSD register into its fields and looks up table values.
// ----------------------------------------------------------------------------
module sdcsd_unpack (
    input  wire  sdcsd_pkg::t_csd_in     i_csd,
    output sdcsd_pkg::t_csd_fields       o_fields
);

    logic [63:0] hi;
    logic [63:0] lo;

    assign hi = i_csd.csd_high;
    assign lo = i_csd.csd_low;

    always_comb begin
        o_fields.ver           = hi[63:62];
        o_fields.rate_unit     = sdcsd_pkg::rate_unit_tenth(hi[34:32]);
        o_fields.rate_mant     = sdcsd_pkg::mant_value(hi[38:35]);
        o_fields.ccc           = hi[31:20];
        o_fields.time_unit_ns  = (hi[50:48] == 3'd0);
        o_fields.time_unit     = sdcsd_pkg::time_unit_tenth(hi[50:48]);
        o_fields.time_mant     = sdcsd_pkg::mant_value(hi[54:51]);
        o_fields.time_small    = sdcsd_pkg::mant_ceil_tenth(hi[54:51]);
        o_fields.nsac          = hi[47:40];
        // c_size straddles the two halves
        o_fields.csize_std     = {hi[9:0], lo[63:62]};
        o_fields.size_mult     = lo[49:47];
        o_fields.csize_hc      = {hi[5:0], lo[63:48]};
        o_fields.read_bl_len   = hi[19:16];
        o_fields.write_bl_len  = lo[25:22];
        o_fields.wr_speed_code = lo[28:26];
        o_fields.flags         = {lo[21], hi[13], hi[14], hi[15]};
    end

endmodule
`default_nettype wire

// ===== rtl/core/sd_csd_register_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sd_csd_register_decoder
// Decodes an SD/MMC CSD register (structure versions 1.0 and 2.0).
// ----------------------------------------------------------------------------
// A register is taken whenever i_start is high; o_busy never rises, so a new
// transaction can be issued every cycle. Each result appears on o_result for
// exactly one cycle with o_done high, after the registered stages in turn:
// one slices fields and looks up tables, one does the multiplies and capacity
// shift, one selects by structure version. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sd_csd_register_decoder (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  sdcsd_pkg::t_csd_in  i_csd,
    output logic                      o_busy,
    output logic                      o_done,
    output sdcsd_pkg::t_csd_out       o_result
);

    sdcsd_pkg::t_csd_fields fields;

    // stage 1
    logic                   r_v1;
    sdcsd_pkg::t_csd_fields r_f1;

    // stage 2
    logic        r_v2;
    logic [1:0]  r_ver2;
    logic [26:0] r_time_ns2;
    logic [14:0] r_clocks2;
    logic [29:0] r_rate2;
    logic [11:0] r_ccc2;
    logic [32:0] r_cap_std2;
    logic [32:0] r_cap_hc2;
    logic [3:0]  r_rbl2;
    logic [3:0]  r_wbl2;
    logic [2:0]  r_r2w2;
    logic [3:0]  r_flags2;

    logic [26:0] n_time_ns2;
    logic [14:0] n_clocks2;
    logic [29:0] n_rate2;
    logic [32:0] n_cap_std2;
    logic [32:0] n_cap_hc2;
    logic [26:0] time_prod;
    logic [21:0] csize_std_p1;
    logic [3:0]  shift_amt;
    logic [22:0] csize_hc_p1;

    // stage 3
    logic                 r_v3;
    sdcsd_pkg::t_csd_out  r_out;
    sdcsd_pkg::t_csd_out  n_out;

    sdcsd_unpack u_unpack (
        .i_csd    (i_csd),
        .o_fields (fields)
    );

    assign o_busy = 1'b0;

    always_comb begin
        n_rate2      = 30'(r_f1.rate_unit * r_f1.rate_mant);
        time_prod    = 27'(r_f1.time_unit * r_f1.time_mant);
        // 1 ns unit needs rounding up; larger units divide evenly by ten
        n_time_ns2   = r_f1.time_unit_ns ? {23'd0, r_f1.time_small} : time_prod;
        n_clocks2    = 15'(r_f1.nsac * sdcsd_pkg::NSAC_SCALE);
        csize_std_p1 = {10'd0, r_f1.csize_std} + 22'd1;
        shift_amt    = {1'b0, r_f1.size_mult} + 4'd2;
        n_cap_std2   = {11'd0, csize_std_p1 << shift_amt};
        csize_hc_p1  = {1'b0, r_f1.csize_hc} + 23'd1;
        n_cap_hc2    = {csize_hc_p1, 10'd0};
    end

    always_comb begin
        n_out = '0;
        case (r_ver2)
            sdcsd_pkg::VER_STD: begin
                n_out.decode_status      = sdcsd_pkg::STATUS_STD;
                n_out.access_time_ns     = r_time_ns2;
                n_out.access_time_clocks = r_clocks2;
                n_out.max_transfer_rate  = r_rate2;
                n_out.command_classes    = r_ccc2;
                n_out.capacity_blocks    = r_cap_std2;
                n_out.read_block_bits    = r_rbl2;
                n_out.write_block_bits   = r_wbl2;
                n_out.write_speed_factor = r_r2w2;
                n_out.access_flags       = r_flags2;
            end
            sdcsd_pkg::VER_HC: begin
                n_out.decode_status      = sdcsd_pkg::STATUS_HC;
                n_out.max_transfer_rate  = r_rate2;
                n_out.command_classes    = r_ccc2;
                n_out.capacity_blocks    = r_cap_hc2;
                n_out.read_block_bits    = sdcsd_pkg::HC_BLOCK_BITS;
                n_out.write_block_bits   = sdcsd_pkg::HC_BLOCK_BITS;
                n_out.write_speed_factor = sdcsd_pkg::HC_WR_SPEED;
            end
            default: begin
                n_out.decode_status = sdcsd_pkg::STATUS_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1       <= fields;
        r_ver2     <= r_f1.ver;
        r_time_ns2 <= n_time_ns2;
        r_clocks2  <= n_clocks2;
        r_rate2    <= n_rate2;
        r_ccc2     <= r_f1.ccc;
        r_cap_std2 <= n_cap_std2;
        r_cap_hc2  <= n_cap_hc2;
        r_rbl2     <= r_f1.read_bl_len;
        r_wbl2     <= r_f1.write_bl_len;
        r_r2w2     <= r_f1.wr_speed_code;
        r_flags2   <= r_f1.flags;
        r_out      <= n_out;
    end

    assign o_done   = r_v3;
    assign o_result = r_out;

endmodule
`default_nettype wire
